[src/wspi_pkg.sv]
package wspi_pkg;

    localparam int CountW = 16;
    localparam int GainW  = 16;
    localparam int LimW   = 10;
    localparam int FracW  = 8;
    localparam int ProdW  = GainW + 1 + CountW;
    localparam int SumW   = ProdW + 1;
    localparam int TdataW = 16;

    typedef enum logic [1:0] {
        REG_TARGET_COUNT = 2'd0,
        REG_PROP_GAIN    = 2'd1,
        REG_INTEG_GAIN   = 2'd2,
        REG_OUT_LIMIT    = 2'd3
    } cfg_idx_t;

    localparam logic signed [CountW-1:0] TARGET_RST = 16'sd0;
    localparam logic [GainW-1:0]         PROP_RST   = 16'd4608;
    localparam logic [GainW-1:0]         INTEG_RST  = 16'd38;
    localparam logic [LimW-1:0]          LIMIT_RST  = 10'd900;

    typedef logic signed [ProdW-1:0] prod_t;
    typedef logic [LimW-1:0]         duty_t;

endpackage

[src/wspi_drive_calc.sv]
module wspi_drive_calc (
    input  wspi_pkg::prod_t pterm,
    input  wspi_pkg::prod_t iterm,
    input  wspi_pkg::duty_t limit,
    output wspi_pkg::duty_t drive
);

    localparam int PadW = wspi_pkg::ProdW - wspi_pkg::LimW - wspi_pkg::FracW;

    logic signed [wspi_pkg::ProdW-1:0] lim_q;
    logic signed [wspi_pkg::ProdW-1:0] iterm_c;
    logic signed [wspi_pkg::SumW-1:0]  sum;
    logic signed [wspi_pkg::SumW-1:0]  sum_c;
    logic signed [wspi_pkg::SumW-1:0]  lim_w;

    always_comb begin
        lim_q   = $signed({{PadW{1'b0}}, limit, {wspi_pkg::FracW{1'b0}}});
        lim_w   = {lim_q[wspi_pkg::ProdW-1], lim_q};
        iterm_c = (iterm > lim_q) ? lim_q : iterm;
        sum     = {pterm[wspi_pkg::ProdW-1], pterm} + {iterm_c[wspi_pkg::ProdW-1], iterm_c};
        priority if (sum > lim_w) begin
            sum_c = lim_w;
        end else if (sum < 0) begin
            sum_c = '0;
        end else begin
            sum_c = sum;
        end
        drive = sum_c[wspi_pkg::FracW +: wspi_pkg::LimW];
    end

endmodule

[src/wheel_speed_pi_controller.sv]
// channel | dir | tdata fields (low bit up)         | tuser | tlast
// s_      | in  | pulse_count[15:0]                 | -     | -
// m_      | out | drive_duty[9:0], zero pad [15:10] | -     | -
// cfg_    | in  | write enable, index 0..3, data[15:0]
// One word per cycle unless m_tready stalls; each word passes input then output register.
// Input register holds error and integral; gain multiplies and clamp feed the output register.
// Synchronous active-low reset clears integral and valids and loads config defaults.
// A stall holds the output stage and a full input stage; s_tready is high if either is free.
module wheel_speed_pi_controller (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [wspi_pkg::TdataW-1:0]      s_tdata,   // [15:0] pulse_count
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [wspi_pkg::TdataW-1:0]      m_tdata,   // [9:0] drive_duty, [15:10] zero
    input  logic                             cfg_wr_en,
    input  wspi_pkg::cfg_idx_t               cfg_wr_idx,
    input  logic [wspi_pkg::GainW-1:0]       cfg_wr_data
);

    localparam int GainPadW  = wspi_pkg::ProdW - wspi_pkg::GainW;
    localparam int CountPadW = wspi_pkg::ProdW - wspi_pkg::CountW;

    logic signed [wspi_pkg::CountW-1:0] target_reg;
    logic [wspi_pkg::GainW-1:0]         prop_gain_reg;
    logic [wspi_pkg::GainW-1:0]         integ_gain_reg;
    wspi_pkg::duty_t                    limit_reg;

    logic signed [wspi_pkg::CountW-1:0] integ_reg, integ_next;
    logic signed [wspi_pkg::CountW-1:0] err;

    logic                               v1_reg, v1_next;
    logic                               v2_reg, v2_next;
    logic signed [wspi_pkg::CountW-1:0] err1_reg;
    logic signed [wspi_pkg::CountW-1:0] integ1_reg;
    wspi_pkg::prod_t                    pterm;
    wspi_pkg::prod_t                    iterm;
    wspi_pkg::duty_t                    duty_reg;
    wspi_pkg::duty_t                    duty_calc;

    logic out_free, s_accept;

    always_comb begin
        out_free = !v2_reg || m_tready;
        s_tready = !v1_reg || out_free;
        s_accept = s_tvalid && s_tready;
        err      = target_reg - $signed(s_tdata[wspi_pkg::CountW-1:0]);
        integ_next = s_accept ? (integ_reg + err) : integ_reg;
        v1_next  = s_tready ? s_tvalid : v1_reg;
        v2_next  = out_free ? v1_reg : v2_reg;
        pterm    = $signed({{GainPadW{1'b0}}, prop_gain_reg})
                 * $signed({{CountPadW{err1_reg[wspi_pkg::CountW-1]}}, err1_reg});
        iterm    = $signed({{GainPadW{1'b0}}, integ_gain_reg})
                 * $signed({{CountPadW{integ1_reg[wspi_pkg::CountW-1]}}, integ1_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg     <= wspi_pkg::TARGET_RST;
            prop_gain_reg  <= wspi_pkg::PROP_RST;
            integ_gain_reg <= wspi_pkg::INTEG_RST;
            limit_reg      <= wspi_pkg::LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_idx)
                wspi_pkg::REG_TARGET_COUNT: target_reg     <= $signed(cfg_wr_data);
                wspi_pkg::REG_PROP_GAIN:    prop_gain_reg  <= cfg_wr_data;
                wspi_pkg::REG_INTEG_GAIN:   integ_gain_reg <= cfg_wr_data;
                wspi_pkg::REG_OUT_LIMIT:    limit_reg      <= cfg_wr_data[wspi_pkg::LimW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end else begin
            integ_reg <= integ_next;
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            err1_reg   <= err;
            integ1_reg <= integ_next;
        end
        if (out_free) begin
            duty_reg <= duty_calc;
        end
    end

    wspi_drive_calc u_calc (
        .pterm (pterm),
        .iterm (iterm),
        .limit (limit_reg),
        .drive (duty_calc)
    );

    assign m_tvalid = v2_reg;
    assign m_tdata  = {{(wspi_pkg::TdataW - wspi_pkg::LimW){1'b0}}, duty_reg};

    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    a_integ_only_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(integ_reg))
        else $error("integral changed without an accepted word");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output word lost during stall");

    a_stage1_feeds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && out_free) |=> v2_reg)
        else $error("stage one word dropped");

endmodule

[verif/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit = 200000;
    localparam int          NumPhases  = 8;
    localparam int          PhaseItems = 80;

    typedef struct packed {
        logic [15:0]     pulse;
        logic            typed;
        wspi_pkg::duty_t duty;
    } dir_row_t;

    typedef struct packed {
        logic [15:0]     target;
        logic [15:0]     kp;
        logic [15:0]     ki;
        wspi_pkg::duty_t lim;
        logic            rnd;
    } phase_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [15:0]          m_tdata;
    logic                 cfg_wr_en   = 1'b0;
    wspi_pkg::cfg_idx_t   cfg_wr_idx  = wspi_pkg::REG_TARGET_COUNT;
    logic [15:0]          cfg_wr_data = '0;

    logic [15:0]          ctl_target   = wspi_pkg::TARGET_RST;
    logic [15:0]          ctl_kp       = wspi_pkg::PROP_RST;
    logic [15:0]          ctl_ki       = wspi_pkg::INTEG_RST;
    wspi_pkg::duty_t      ctl_limit    = wspi_pkg::LIMIT_RST;
    logic [15:0]          err_integral = '0;

    wspi_pkg::duty_t      duty_q [$];
    wspi_pkg::duty_t      want;
    int unsigned          mismatches = 0;
    int unsigned          cycles = 0;
    int unsigned          idle_pct = 0;
    int unsigned          stall_pct = 0;

    dir_row_t             dir_rows [20];
    phase_t               phases [NumPhases];

    wheel_speed_pi_controller dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_idx  (cfg_wr_idx),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (duty_q.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected word: m_tdata=%h", m_tdata);
            end else begin
                want = duty_q.pop_front();
                if (m_tdata !== {6'd0, want}) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("drive_duty mismatch: expected %0d, got %0d (m_tdata=%h)",
                                 want, m_tdata[9:0], m_tdata);
                end
            end
        end
    end

    function automatic wspi_pkg::duty_t next_duty(input logic [15:0] pulse);
        logic [15:0] err;
        longint      e;
        longint      ig;
        longint      lim;
        longint      iterm;
        longint      sum;
        err = ctl_target - pulse;
        err_integral = err_integral + err;
        e = $signed(err);
        ig = $signed(err_integral);
        lim = longint'(ctl_limit) * 256;
        iterm = longint'(ctl_ki) * ig;
        if (iterm > lim)
            iterm = lim;
        sum = longint'(ctl_kp) * e + iterm;
        if (sum > lim)
            sum = lim;
        if (sum < 0)
            sum = 0;
        return wspi_pkg::duty_t'(sum >>> 8);
    endfunction

    task automatic send_word(input logic [15:0] pulse, input logic typed,
                             input wspi_pkg::duty_t typed_duty);
        wspi_pkg::duty_t d;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pulse;
        do @(posedge aclk); while (!s_tready);
        d = next_duty(pulse);
        duty_q.push_back(typed ? typed_duty : d);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (duty_q.size() != 0);
    endtask

    task automatic configure(input phase_t p);
        cfg_wr_en   <= 1'b1;
        cfg_wr_idx  <= wspi_pkg::REG_TARGET_COUNT;
        cfg_wr_data <= p.target;
        @(posedge aclk);
        cfg_wr_idx  <= wspi_pkg::REG_PROP_GAIN;
        cfg_wr_data <= p.kp;
        @(posedge aclk);
        cfg_wr_idx  <= wspi_pkg::REG_INTEG_GAIN;
        cfg_wr_data <= p.ki;
        @(posedge aclk);
        cfg_wr_idx  <= wspi_pkg::REG_OUT_LIMIT;
        cfg_wr_data <= {6'($urandom), p.lim};
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        ctl_target = p.target;
        ctl_kp     = p.kp;
        ctl_ki     = p.ki;
        ctl_limit  = p.lim;
    endtask

    function automatic logic [15:0] rand_pulse();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return ctl_target + 16'($urandom_range(64)) - 16'd32;
        else if (pick < 85)
            return ctl_target + 16'($urandom_range(4096)) - 16'd2048;
        return 16'($urandom);
    endfunction

    initial begin
        phase_t p;
        dir_rows = '{
            '{16'h0000, 1'b1, 10'd0},
            '{16'h8000, 1'b1, 10'd0},
            '{16'h7fff, 1'b1, 10'd0},
            '{16'hff9c, 1'b1, 10'd900},
            '{16'hffff, 1'b0, 10'd0},
            '{16'h0001, 1'b0, 10'd0},
            '{16'h0005, 1'b0, 10'd0},
            '{16'hfff0, 1'b0, 10'd0},
            '{16'h000a, 1'b0, 10'd0},
            '{16'h0100, 1'b0, 10'd0},
            '{16'h1000, 1'b0, 10'd0},
            '{16'h1000, 1'b0, 10'd0},
            '{16'hffff, 1'b0, 10'd0},
            '{16'hfffe, 1'b0, 10'd0},
            '{16'hf000, 1'b0, 10'd0},
            '{16'h1234, 1'b0, 10'd0},
            '{16'haaaa, 1'b0, 10'd0},
            '{16'h5555, 1'b0, 10'd0},
            '{16'h8001, 1'b0, 10'd0},
            '{16'h0000, 1'b0, 10'd0}
        };
        phases = '{
            '{16'd100,   16'd4608,  16'd38,    10'd900,  1'b0},
            '{16'd0,     16'd0,     16'd65535, 10'd1023, 1'b0},
            '{16'h8000,  16'd65535, 16'd0,     10'd1023, 1'b0},
            '{16'h7fff,  16'd256,   16'd1,     10'd0,    1'b0},
            '{16'd500,   16'd65535, 16'd65535, 10'd1,    1'b0},
            '{16'hff38,  16'd128,   16'd16,    10'd512,  1'b0},
            '{16'd0,     16'd0,     16'd0,     10'd0,    1'b1},
            '{16'd0,     16'd0,     16'd0,     10'd0,    1'b1}
        };

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].pulse, dir_rows[i].typed, dir_rows[i].duty);
        drain();

        for (int ph = 0; ph < NumPhases; ph++) begin
            p = phases[ph];
            if (p.rnd) begin
                p.target = 16'($urandom);
                p.kp     = 16'($urandom_range(2048));
                p.ki     = 16'($urandom_range(256));
                p.lim    = 10'($urandom_range(1023));
            end
            configure(p);
            case (ph % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 49;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 49;
                end
                default: begin
                    idle_pct  = 20;
                    stall_pct = 20;
                end
            endcase
            for (int k = 0; k < PhaseItems; k++) begin
                if (k == PhaseItems / 2 && ph % 2 == 1)
                    drain();
                send_word(rand_pulse(), 1'b0, '0);
            end
            drain();
        end

        idle_pct  = 0;
        stall_pct = 0;
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && duty_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
